@@ rtl/core/mme_pkg.sv @@
`timescale 1ns / 1ps

package mme_pkg;

	localparam int MAX_DIM_DEF    = 16;
	localparam int DATA_WIDTH_DEF = 16;

	localparam int OP_W      = 2;
	localparam int IDX_W     = 4;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int ACC_W     = 64;
	localparam int FRAC_W    = 8;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	typedef enum logic [OP_W-1:0] {
		OP_WR_A    = 2'd0,
		OP_WR_B    = 2'd1,
		OP_COMPUTE = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_A    = 2'd0,
		REG_INNER_DIM = 2'd1,
		REG_COLS_B    = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic clear;
		logic issue;
	} mac_ctl_t;

endpackage

@@ rtl/core/mme_if.sv @@
`timescale 1ns / 1ps

interface mme_cmd_if #(
	parameter int DATA_WIDTH = 16
);
	import mme_pkg::*;

	logic                         valid;
	logic                         ready;
	logic [OP_W-1:0]              opcode;
	logic [IDX_W-1:0]             row_index;
	logic [IDX_W-1:0]             col_index;
	logic signed [DATA_WIDTH-1:0] element_value;

	modport source (output valid, opcode, row_index, col_index, element_value, input ready);
	modport sink (input valid, opcode, row_index, col_index, element_value, output ready);
endinterface

interface mme_res_if #(
	parameter int DATA_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] product_value;
	logic                         status;

	modport source (output valid, product_value, status, input ready);
	modport sink (input valid, product_value, status, output ready);
endinterface

@@ rtl/core/mme_store.sv @@
`timescale 1ns / 1ps

module mme_store #(
	parameter int AW = 4,
	parameter int DW = 16
) (
	input  logic                clk,
	input  logic                we_a,
	input  logic                we_b,
	input  logic [2*AW-1:0]     waddr,
	input  logic [DW-1:0]       wdata,
	input  logic                re,
	input  logic [2*AW-1:0]     raddr_a,
	input  logic [2*AW-1:0]     raddr_b,
	output logic [DW-1:0]       rdata_a,
	output logic [DW-1:0]       rdata_b
);
	localparam int DEPTH = 2 ** (2 * AW);

	logic [DW-1:0] mem_a [DEPTH];
	logic [DW-1:0] mem_b [DEPTH];

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_a[raddr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			mem_b[waddr] <= wdata;
		end
		if (re) begin
			rdata_b <= mem_b[raddr_b];
		end
	end

endmodule

@@ rtl/core/mme_mac.sv @@
`timescale 1ns / 1ps

module mme_mac #(
	parameter int DW = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mme_pkg::mac_ctl_t     ctl,
	input  logic [DW-1:0]         a_data,
	input  logic [DW-1:0]         b_data,
	output logic                  busy,
	output logic signed [DW-1:0]  result
);
	import mme_pkg::*;

	localparam logic signed [ACC_W-1:0] HI = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] LO = ~HI;
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	logic                       rd_vld_s1;
	logic                       mul_vld_s2;
	logic signed [2*DW-1:0]     prod_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    prod_ext;
	logic signed [ACC_W-1:0]    sum;
	logic signed [ACC_W-1:0]    sum_sat;
	logic signed [ACC_W-1:0]    shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			mul_vld_s2 <= 1'b0;
		end else begin
			rd_vld_s1  <= ctl.issue;
			mul_vld_s2 <= rd_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(a_data) * $signed(b_data);
	end

	always_comb begin
		prod_ext = ACC_W'(prod_s2);
		sum      = acc_q + prod_ext;
		sum_sat  = sum;
		if (acc_q[ACC_W-1] == prod_ext[ACC_W-1] && sum[ACC_W-1] != acc_q[ACC_W-1]) begin
			sum_sat = prod_ext[ACC_W-1] ? ACC_MIN : ACC_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (mul_vld_s2) begin
			acc_q <= sum_sat;
		end
	end

	always_comb begin
		shifted = acc_q >>> FRAC_W;
		if (shifted > HI) begin
			result = HI[DW-1:0];
		end else if (shifted < LO) begin
			result = LO[DW-1:0];
		end else begin
			result = shifted[DW-1:0];
		end
	end

	assign busy = rd_vld_s1 | mul_vld_s2;

endmodule

@@ rtl/core/matrix_multiply_engine.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Fields                                              Accepted when
// cmd      in   opcode, row_index, col_index, element_value         valid & ready
// res      out  product_value, status                               valid & ready
// cfg      in   cfg_we, cfg_index, cfg_data                         cfg_we
// Compute: accept, min(inner_dim, MAX_DIM) multiply-accumulates at one per cycle, drain of the
// store read and multiply registers, output load; out of range or inner size 0: only output load.
// Reset clears control state and sets all three sizes to 16; the stores are not cleared.
// A result held in the output word does not stop the next item from entering; only a
// finished compute waits there until the output word is free.

module matrix_multiply_engine #(
	parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
	parameter int DATA_WIDTH = mme_pkg::DATA_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mme_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mme_pkg::CFG_W-1:0]       cfg_data,
	mme_cmd_if.sink                         cmd,
	mme_res_if.source                       res
);
	import mme_pkg::*;

	localparam int AW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CMPW = (CFG_W > AW + 1) ? CFG_W : AW + 1;
	localparam logic [CMPW-1:0] DIM_MAX = CMPW'(MAX_DIM);

	state_t state_q, state_d;

	logic [CFG_W-1:0]       rows_a_q, inner_dim_q, cols_b_q;
	logic [CMPW-1:0]        eff_rows, eff_inner, eff_cols;
	logic [CMPW-1:0]        row_ext, col_ext;
	logic                   cmd_acc, is_compute, cmp_err, wr_ok;
	logic                   we_a, we_b;
	logic [AW-1:0]          row_q, col_q, k_q;
	logic [AW:0]            n_q;
	logic                   err_q;
	logic                   last_issue;
	logic                   load_res;
	mac_ctl_t               mac_ctl;
	logic                   mac_busy;
	logic signed [DATA_WIDTH-1:0] mac_result;
	logic [DATA_WIDTH-1:0]  rdata_a, rdata_b;
	logic                   res_vld_q, res_status_q;
	logic signed [DATA_WIDTH-1:0] res_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= CFG_RESET;
			inner_dim_q <= CFG_RESET;
			cols_b_q    <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROWS_A:    rows_a_q    <= cfg_data;
				REG_INNER_DIM: inner_dim_q <= cfg_data;
				REG_COLS_B:    cols_b_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_rows  = (CMPW'(rows_a_q) < DIM_MAX) ? CMPW'(rows_a_q) : DIM_MAX;
		eff_inner = (CMPW'(inner_dim_q) < DIM_MAX) ? CMPW'(inner_dim_q) : DIM_MAX;
		eff_cols  = (CMPW'(cols_b_q) < DIM_MAX) ? CMPW'(cols_b_q) : DIM_MAX;
		row_ext   = CMPW'(cmd.row_index);
		col_ext   = CMPW'(cmd.col_index);
		cmd_acc   = cmd.valid & cmd.ready;
		cmp_err   = (row_ext >= eff_rows) || (col_ext >= eff_cols);
		wr_ok     = (row_ext < DIM_MAX) && (col_ext < DIM_MAX);
		we_a      = 1'b0;
		we_b      = 1'b0;
		is_compute = 1'b0;
		unique case (op_t'(cmd.opcode))
			OP_WR_A:    we_a = cmd_acc & wr_ok;
			OP_WR_B:    we_b = cmd_acc & wr_ok;
			OP_COMPUTE: is_compute = cmd_acc;
			default: ;
		endcase
	end

	assign last_issue = ((AW+1)'({1'b0, k_q}) + (AW+1)'(1)) == n_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (is_compute) begin
					state_d = (cmp_err || eff_inner == '0) ? ST_FINISH : ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!mac_busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!res_vld_q || res.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready     = 1'b0;
		mac_ctl.clear = 1'b0;
		mac_ctl.issue = 1'b0;
		load_res      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready     = 1'b1;
				mac_ctl.clear = is_compute;
			end
			ST_ISSUE:  mac_ctl.issue = 1'b1;
			ST_DRAIN: ;
			ST_FINISH: load_res = !res_vld_q || res.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (is_compute) begin
				k_q   <= '0;
				err_q <= cmp_err;
			end else if (mac_ctl.issue) begin
				k_q <= k_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_compute) begin
			row_q <= row_ext[AW-1:0];
			col_q <= col_ext[AW-1:0];
			n_q   <= eff_inner[AW:0];
		end
	end

	mme_store #(
		.AW (AW),
		.DW (DATA_WIDTH)
	) u_store (
		.clk     (clk),
		.we_a    (we_a),
		.we_b    (we_b),
		.waddr   ({row_ext[AW-1:0], col_ext[AW-1:0]}),
		.wdata   (cmd.element_value),
		.re      (mac_ctl.issue),
		.raddr_a ({row_q, k_q}),
		.raddr_b ({k_q, col_q}),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	mme_mac #(
		.DW (DATA_WIDTH)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a_data (rdata_a),
		.b_data (rdata_b),
		.busy   (mac_busy),
		.result (mac_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (load_res) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_val_q    <= err_q ? '0 : mac_result;
			res_status_q <= err_q;
		end
	end

	assign res.valid         = res_vld_q;
	assign res.product_value = res_val_q;
	assign res.status        = res_status_q;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import mme_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES  = 400;
	localparam int STORE_DEPTH  = MAX_DIM_DEF * MAX_DIM_DEF;
	localparam int SA_W         = $clog2(STORE_DEPTH);

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam bit STAT_OK    = 1'b0;
	localparam bit STAT_RANGE = 1'b1;

	typedef logic signed [DATA_WIDTH_DEF-1:0] elem_t;

	localparam elem_t Q_MAX  = 16'sh7FFF;
	localparam elem_t Q_MIN  = 16'sh8000;
	localparam elem_t Q_ONES = 16'shFFFF;
	localparam elem_t Q_LSB  = 16'sh0001;
	localparam elem_t Q_ONE  = 16'sh0100;
	localparam elem_t Q_NEG1 = 16'shFF00;
	localparam elem_t Q_ZERO = 16'sh0000;

	localparam longint SAT_HI = (longint'(1) <<< (DATA_WIDTH_DEF - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		elem_t            value;
		bit               known;
		elem_t            known_value;
		bit               known_status;
	} cmd_word_t;

	typedef struct packed {
		elem_t value;
		bit    status;
	} product_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	mme_cmd_if #(.DATA_WIDTH(DATA_WIDTH_DEF)) cmd ();
	mme_res_if #(.DATA_WIDTH(DATA_WIDTH_DEF)) res ();

	matrix_multiply_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.res       (res)
	);

	always #HALF_PERIOD clk = ~clk;

	elem_t a_mem [STORE_DEPTH];
	elem_t b_mem [STORE_DEPTH];
	bit a_written [STORE_DEPTH];
	bit b_written [STORE_DEPTH];
	logic [CFG_W-1:0] size_rows = CFG_RESET;
	logic [CFG_W-1:0] size_inner = CFG_RESET;
	logic [CFG_W-1:0] size_cols = CFG_RESET;

	product_t expected_products [$];
	cmd_word_t cur_word;
	cmd_word_t directed_table [24];

	int send_idle_pct;
	int recv_stall_pct;
	bit hold_armed;
	int errors;
	int words_in;
	int products_checked;
	int settings_run;

	function automatic logic [SA_W-1:0] store_addr(input int row, input int col);
		return SA_W'(row * MAX_DIM_DEF + col);
	endfunction

	function automatic int eff_size(input logic [CFG_W-1:0] r);
		return (r > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(r);
	endfunction

	function automatic product_t multiply_element(input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col);
		longint acc;
		product_t p;
		int k;
		acc = 0;
		p.value = '0;
		p.status = STAT_RANGE;
		if (row >= eff_size(size_rows) || col >= eff_size(size_cols)) begin
			return p;
		end
		for (k = 0; k < eff_size(size_inner); k++) begin
			acc += longint'(a_mem[store_addr(int'(row), k)]) *
				longint'(b_mem[store_addr(k, int'(col))]);
		end
		acc = acc >>> FRAC_W;
		if (acc > SAT_HI) begin
			acc = SAT_HI;
		end
		if (acc < SAT_LO) begin
			acc = SAT_LO;
		end
		p.value = elem_t'(acc);
		p.status = STAT_OK;
		return p;
	endfunction

	function automatic cmd_word_t make_word(input logic [OP_W-1:0] op, input int row,
			input int col, input elem_t value, input bit known = 1'b0,
			input elem_t known_value = '0, input bit known_status = STAT_OK);
		cmd_word_t w;
		w.opcode = op;
		w.row = IDX_W'(row);
		w.col = IDX_W'(col);
		w.value = value;
		w.known = known;
		w.known_value = known_value;
		w.known_status = known_status;
		return w;
	endfunction

	function automatic elem_t pick_value();
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(3))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return Q_ZERO;
					default: return Q_ONES;
				endcase
			end
			1, 2: return elem_t'(int'($urandom_range(2047)) - 1024);
			default: return elem_t'($urandom);
		endcase
	endfunction

	// track the store and queue up the product for every accepted compute
	always @(posedge clk) begin
		product_t due;
		if (arst_n && cmd.valid && cmd.ready) begin
			words_in++;
			case (cmd.opcode)
				OP_WR_A: a_mem[store_addr(int'(cmd.row_index), int'(cmd.col_index))] =
					cmd.element_value;
				OP_WR_B: b_mem[store_addr(int'(cmd.row_index), int'(cmd.col_index))] =
					cmd.element_value;
				OP_COMPUTE: begin
					if (cur_word.known) begin
						due.value = cur_word.known_value;
						due.status = cur_word.known_status;
					end else begin
						due = multiply_element(cmd.row_index, cmd.col_index);
					end
					expected_products = {expected_products, due};
				end
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		product_t want;
		if (arst_n && res.valid && res.ready) begin
			if (expected_products.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got value %h status %0d",
					$time, res.product_value, res.status);
			end else begin
				want = expected_products.pop_front();
				products_checked++;
				if (res.product_value !== want.value) begin
					errors++;
					$display("%0t: product_value expected %h, got %h",
						$time, want.value, res.product_value);
				end
				if (res.status !== want.status) begin
					errors++;
					$display("%0t: status expected %0d, got %0d", $time, want.status, res.status);
				end
			end
		end
	end

	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_word(input cmd_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.opcode <= w.opcode;
		cmd.row_index <= w.row;
		cmd.col_index <= w.col;
		cmd.element_value <= w.value;
		cur_word <= w;
		do begin
			@(posedge clk);
		end while (!cmd.ready);
		if (w.opcode == OP_WR_A) begin
			a_written[store_addr(int'(w.row), int'(w.col))] = 1'b1;
		end
		if (w.opcode == OP_WR_B) begin
			b_written[store_addr(int'(w.row), int'(w.col))] = 1'b1;
		end
	endtask

	task automatic wait_idle();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (expected_products.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_sizes(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
			input logic [CFG_W-1:0] cols);
		cfg_we <= 1'b1;
		cfg_index <= REG_ROWS_A;
		cfg_data <= rows;
		@(posedge clk);
		cfg_index <= REG_INNER_DIM;
		cfg_data <= inner;
		@(posedge clk);
		cfg_index <= REG_COLS_B;
		cfg_data <= cols;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_rows = rows;
		size_inner = inner;
		size_cols = cols;
		settings_run++;
	endtask

	task automatic random_words(input int n_words);
		int sent;
		int pick;
		int er;
		int ei;
		int ec;
		int row;
		int col;
		int k;
		bit safe;
		sent = 0;
		er = eff_size(size_rows);
		ei = eff_size(size_inner);
		ec = eff_size(size_cols);
		while (sent < n_words) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				row = (er == 0 || $urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(er - 1);
				col = (ec == 0 || $urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(ec - 1);
				if (row < er && col < ec) begin
					for (k = 0; k < ei; k++) begin
						if (!a_written[store_addr(row, k)] || $urandom_range(3) == 0) begin
							send_word(make_word(OP_WR_A, row, k, pick_value()));
							sent++;
						end
						if (!b_written[store_addr(k, col)] || $urandom_range(3) == 0) begin
							send_word(make_word(OP_WR_B, k, col, pick_value()));
							sent++;
						end
					end
				end
				send_word(make_word(OP_COMPUTE, row, col, elem_t'($urandom)));
				sent++;
			end else if (pick < 82) begin
				send_word(make_word($urandom_range(1) ? OP_WR_B : OP_WR_A,
					$urandom_range(15), $urandom_range(15), pick_value()));
				sent++;
			end else if (pick < 90) begin
				send_word(make_word(OP_UNUSED, $urandom_range(15), $urandom_range(15),
					elem_t'($urandom)));
			end else begin
				row = $urandom_range(15);
				col = $urandom_range(15);
				safe = 1'b1;
				if (row < er && col < ec) begin
					for (k = 0; k < ei; k++) begin
						if (!a_written[store_addr(row, k)] || !b_written[store_addr(k, col)]) begin
							safe = 1'b0;
						end
					end
				end
				if (safe) begin
					send_word(make_word(OP_COMPUTE, row, col, elem_t'($urandom)));
					sent++;
				end
			end
		end
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
			input logic [CFG_W-1:0] cols, input int idle_pct, input int stall_pct,
			input bit long_hold, input int n_words);
		wait_idle();
		apply_sizes(rows, inner, cols);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		hold_armed = long_hold;
		random_words(n_words);
	endtask

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int idle_modes [4];
		int stall_modes [4];
		int i;
		idle_modes = '{0, 61, 0, 37};
		stall_modes = '{0, 0, 61, 37};
		cmd.valid <= 1'b0;
		cmd.opcode <= OP_WR_A;
		cmd.row_index <= '0;
		cmd.col_index <= '0;
		cmd.element_value <= '0;
		cur_word <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ROWS_A;
		cfg_data <= '0;

		directed_table = '{
			make_word(OP_WR_A, 0, 0, Q_MAX),
			make_word(OP_WR_A, 0, 1, Q_MAX),
			make_word(OP_WR_B, 0, 0, Q_MAX),
			make_word(OP_WR_B, 1, 0, Q_MAX),
			make_word(OP_COMPUTE, 0, 0, Q_ZERO, 1'b1, Q_MAX, STAT_OK),
			make_word(OP_WR_B, 0, 1, Q_MIN),
			make_word(OP_WR_B, 1, 1, Q_MIN),
			make_word(OP_COMPUTE, 0, 1, Q_ZERO, 1'b1, Q_MIN, STAT_OK),
			make_word(OP_WR_A, 1, 0, Q_MIN),
			make_word(OP_WR_A, 1, 1, Q_MIN),
			make_word(OP_COMPUTE, 1, 1, Q_ZERO, 1'b1, Q_MAX, STAT_OK),
			make_word(OP_COMPUTE, 2, 0, Q_ZERO, 1'b1, Q_ZERO, STAT_RANGE),
			make_word(OP_COMPUTE, 0, 2, Q_ZERO, 1'b1, Q_ZERO, STAT_RANGE),
			make_word(OP_COMPUTE, 15, 15, Q_ONES, 1'b1, Q_ZERO, STAT_RANGE),
			make_word(OP_UNUSED, 15, 15, Q_ONES),
			make_word(OP_WR_A, 15, 15, Q_LSB),
			make_word(OP_WR_B, 15, 15, Q_ONES),
			make_word(OP_WR_A, 1, 0, Q_ONE),
			make_word(OP_WR_A, 1, 1, Q_NEG1),
			make_word(OP_COMPUTE, 1, 0, Q_ZERO),
			make_word(OP_WR_A, 0, 0, Q_ONES),
			make_word(OP_WR_A, 0, 1, Q_ZERO),
			make_word(OP_WR_B, 0, 0, Q_LSB),
			make_word(OP_COMPUTE, 0, 0, Q_ZERO)
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		apply_sizes(5'd2, 5'd2, 5'd2);
		for (i = 0; i < 24; i++) begin
			send_word(directed_table[i]);
		end

		run_phase(5'd16, 5'd16, 5'd16, 0, 0, 1'b0, 150);
		run_phase(5'd1, 5'd1, 5'd1, 61, 0, 1'b0, 100);
		run_phase(5'd31, 5'd31, 5'd31, 0, 61, 1'b0, 150);
		run_phase(5'd0, 5'd5, 5'd4, 37, 37, 1'b0, 50);
		run_phase(5'd7, 5'd0, 5'd9, 61, 0, 1'b0, 80);
		run_phase(5'd5, 5'd3, 5'd0, 0, 61, 1'b0, 50);
		run_phase(5'd4, 5'd3, 5'd5, 0, 0, 1'b1, 200);
		for (i = 0; i < 4; i++) begin
			run_phase(CFG_W'($urandom_range(1, 16)), CFG_W'($urandom_range(1, 16)),
				CFG_W'($urandom_range(1, 16)), idle_modes[i], stall_modes[i], 1'b0, 100);
		end
		wait_idle();

		if (expected_products.size() != 0) begin
			errors++;
			$display("%0t: results outstanding, expected 0, got %0d",
				$time, expected_products.size());
		end

		$display("summary: %0d words accepted, %0d products checked, %0d mismatches",
			words_in, products_checked, errors);
		$display("summary: %0d size settings incl. zero, over-range and full, one long output hold",
			settings_run);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/mme_pkg.sv
rtl/core/mme_if.sv
rtl/core/mme_store.sv
rtl/core/mme_mac.sv
rtl/core/matrix_multiply_engine.sv
test/testbench.sv
